// ===== hw/rtl/i2crm_pkg.sv =====
// Shared types and constants for the I2C register master.
`timescale 1ns / 1ps
`default_nettype none

package i2crm_pkg;

    // Default limit on transfer length; lengths at or above it are refused.
    localparam int MAX_XFER_DEF = 64;

    // Reset values of the configuration registers.
    localparam logic [6:0] DEV_ADDR_RST  = 7'd41;
    localparam logic [7:0] ACK_LIMIT_RST = 8'd10;

    // Configuration register indexes.
    localparam logic CFG_DEV_ADDR  = 1'b0;
    localparam logic CFG_ACK_LIMIT = 1'b1;

    // Completion status codes.
    localparam logic [1:0] STATUS_SUCCESS = 2'd0;
    localparam logic [1:0] STATUS_NACK    = 2'd1;
    localparam logic [1:0] STATUS_TOO_BIG = 2'd2;

    // Bus sequencer phases.
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_B,
        PH_TX_LO,
        PH_TX_HI,
        PH_ACK_LO,
        PH_ACK_HI,
        PH_RS_A,
        PH_RS_B,
        PH_RS_C,
        PH_RX_LO,
        PH_RX_HI,
        PH_MACK_LO,
        PH_MACK_HI,
        PH_STOP_A,
        PH_STOP_B,
        PH_STOP_C
    } phase_t;

    // Which byte is on the wire.
    typedef enum logic [1:0] {
        ROLE_WADDR,
        ROLE_INDEX,
        ROLE_DATA,
        ROLE_RADDR
    } role_t;

    // One bus tick presented to the sequencer.
    typedef struct packed {
        logic       start_request;
        logic       read_not_write;
        logic [7:0] reg_index;
        logic [7:0] xfer_length;
        logic [7:0] write_byte;
        logic       sda_in;
    } tick_t;

    // Result of one bus tick.
    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       write_take;
        logic [7:0] read_data;
        logic       read_valid;
        logic       read_last;
        logic       done_res;
        logic [1:0] status;
    } result_t;

    // Configuration register contents.
    typedef struct packed {
        logic [6:0] device_address;
        logic [7:0] ack_wait_limit;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/i2crm_engine.sv =====
// Bus sequencer: phase register, bit and byte counters, and per-tick outputs.
`timescale 1ns / 1ps
`default_nettype none

module i2crm_engine
    import i2crm_pkg::*;
#(
    parameter int MAX_XFER = MAX_XFER_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step_en,
    input  wire tick_t   tick,
    input  wire cfg_t    cfg,
    output result_t      res
);

    phase_t     phase_reg, phase_next;
    role_t      role_reg, role_next;
    logic [3:0] bit_cnt_reg, bit_cnt_next;
    logic [7:0] shifter_reg, shifter_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] ack_cnt_reg, ack_cnt_next;
    logic [7:0] index_reg, index_next;
    logic       dir_reg, dir_next;
    logic       fail_reg, fail_next;

    logic [7:0] addr_byte;
    logic       len_bad;
    logic       wait_more;
    logic       bit_last;
    logic       write_path;
    logic       take_byte;
    logic [7:0] rx_byte;

    // Shared decode of the current tick.
    assign addr_byte  = {cfg.device_address, 1'b0};
    assign len_bad    = {1'b0, tick.xfer_length} >= 9'(MAX_XFER);
    assign wait_more  = tick.sda_in && (ack_cnt_reg < cfg.ack_wait_limit);
    assign bit_last   = bit_cnt_reg >= 4'd7;
    assign write_path = (role_reg == ROLE_DATA) || (role_reg == ROLE_INDEX && !dir_reg)
                        || (role_reg == ROLE_WADDR && !tick.sda_in);
    assign take_byte  = (role_reg == ROLE_DATA || (role_reg == ROLE_INDEX && !dir_reg))
                        && (bytes_left_reg != 8'd0);
    assign rx_byte    = {shifter_reg[6:0], tick.sda_in};

    // Next state of the sequencer and its working registers.
    always_comb
    begin
        phase_next      = phase_reg;
        role_next       = role_reg;
        bit_cnt_next    = bit_cnt_reg;
        shifter_next    = shifter_reg;
        bytes_left_next = bytes_left_reg;
        ack_cnt_next    = ack_cnt_reg;
        index_next      = index_reg;
        dir_next        = dir_reg;
        fail_next       = fail_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (tick.start_request && !len_bad)
                begin
                    dir_next        = tick.read_not_write;
                    index_next      = tick.reg_index;
                    bytes_left_next = tick.xfer_length;
                    fail_next       = 1'b0;
                    role_next       = ROLE_WADDR;
                    shifter_next    = addr_byte;
                    bit_cnt_next    = 4'd0;
                    phase_next      = PH_START_B;
                end
            end
            PH_START_B:
                phase_next = PH_TX_LO;
            PH_TX_LO:
                phase_next = PH_TX_HI;
            PH_TX_HI:
            begin
                shifter_next = {shifter_reg[6:0], 1'b0};
                if (bit_last)
                begin
                    bit_cnt_next = 4'd0;
                    phase_next   = PH_ACK_LO;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg + 4'd1;
                    phase_next   = PH_TX_LO;
                end
            end
            PH_ACK_LO:
            begin
                ack_cnt_next = 8'd0;
                phase_next   = PH_ACK_HI;
            end
            PH_ACK_HI:
            begin
                if (wait_more)
                begin
                    ack_cnt_next = ack_cnt_reg + 8'd1;
                end
                else
                begin
                    case (role_reg)
                        ROLE_WADDR:
                        begin
                            if (tick.sda_in)
                            begin
                                fail_next  = 1'b1;
                                phase_next = PH_STOP_A;
                            end
                            else
                            begin
                                role_next    = ROLE_INDEX;
                                shifter_next = index_reg;
                                bit_cnt_next = 4'd0;
                                phase_next   = PH_TX_LO;
                            end
                        end
                        ROLE_RADDR:
                        begin
                            if (bytes_left_reg == 8'd0)
                            begin
                                phase_next = PH_STOP_A;
                            end
                            else
                            begin
                                shifter_next = 8'd0;
                                bit_cnt_next = 4'd0;
                                phase_next   = PH_RX_LO;
                            end
                        end
                        default:
                        begin
                            // Index of a read goes to repeated START; else next data byte, or STOP when none is left.
                            if (role_reg == ROLE_INDEX && dir_reg)
                            begin
                                phase_next = PH_RS_A;
                            end
                            else if (take_byte)
                            begin
                                bytes_left_next = bytes_left_reg - 8'd1;
                                role_next       = ROLE_DATA;
                                shifter_next    = tick.write_byte;
                                bit_cnt_next    = 4'd0;
                                phase_next      = PH_TX_LO;
                            end
                            else
                            begin
                                phase_next = PH_STOP_A;
                            end
                        end
                    endcase
                end
            end
            PH_RS_A:
                phase_next = PH_RS_B;
            PH_RS_B:
                phase_next = PH_RS_C;
            PH_RS_C:
            begin
                role_next    = ROLE_RADDR;
                shifter_next = addr_byte | 8'h01;
                bit_cnt_next = 4'd0;
                phase_next   = PH_START_B;
            end
            PH_RX_LO:
                phase_next = PH_RX_HI;
            PH_RX_HI:
            begin
                shifter_next = rx_byte;
                if (bit_last)
                begin
                    bit_cnt_next = 4'd0;
                    phase_next   = PH_MACK_LO;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg + 4'd1;
                    phase_next   = PH_RX_LO;
                end
            end
            PH_MACK_LO:
                phase_next = PH_MACK_HI;
            PH_MACK_HI:
            begin
                if (bytes_left_reg <= 8'd1)
                begin
                    bytes_left_next = 8'd0;
                    phase_next      = PH_STOP_A;
                end
                else
                begin
                    bytes_left_next = bytes_left_reg - 8'd1;
                    shifter_next    = 8'd0;
                    phase_next      = PH_RX_LO;
                end
            end
            PH_STOP_A:
                phase_next = PH_STOP_B;
            PH_STOP_B:
                phase_next = PH_STOP_C;
            PH_STOP_C:
            begin
                fail_next  = 1'b0;
                phase_next = PH_IDLE;
            end
            default:
                phase_next = PH_IDLE;
        endcase
    end

    // Bus levels and status for the current tick.
    always_comb
    begin
        res = '0;
        res.scl_level   = 1'b1;
        res.sda_release = 1'b1;
        res.busy_res    = 1'b1;
        case (phase_reg)
            PH_IDLE:
            begin
                res.busy_res = 1'b0;
                if (tick.start_request)
                begin
                    if (len_bad)
                    begin
                        res.done_res = 1'b1;
                        res.status   = STATUS_TOO_BIG;
                    end
                    else
                    begin
                        res.busy_res    = 1'b1;
                        res.sda_release = 1'b0;
                    end
                end
            end
            PH_START_B:
            begin
                res.scl_level   = 1'b0;
                res.sda_release = 1'b0;
            end
            PH_TX_LO:
            begin
                res.scl_level   = 1'b0;
                res.sda_release = shifter_reg[7];
            end
            PH_TX_HI:
                res.sda_release = shifter_reg[7];
            PH_ACK_LO:
                res.scl_level = 1'b0;
            PH_ACK_HI:
                res.write_take = !wait_more && write_path && take_byte;
            PH_RS_A:
                res.scl_level = 1'b0;
            PH_RS_B:
                res.scl_level = 1'b1;
            PH_RS_C:
                res.sda_release = 1'b0;
            PH_RX_LO:
                res.scl_level = 1'b0;
            PH_RX_HI:
            begin
                if (bit_last)
                begin
                    res.read_valid = 1'b1;
                    res.read_data  = rx_byte;
                    res.read_last  = bytes_left_reg == 8'd1;
                end
            end
            PH_MACK_LO:
            begin
                res.scl_level   = 1'b0;
                res.sda_release = bytes_left_reg <= 8'd1;
            end
            PH_MACK_HI:
                res.sda_release = bytes_left_reg <= 8'd1;
            PH_STOP_A:
            begin
                res.scl_level   = 1'b0;
                res.sda_release = 1'b0;
            end
            PH_STOP_B:
                res.sda_release = 1'b0;
            PH_STOP_C:
            begin
                res.done_res = 1'b1;
                res.status   = fail_reg ? STATUS_NACK : STATUS_SUCCESS;
            end
            default:
                res.busy_res = 1'b0;
        endcase
    end

    // State registers advance once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            role_reg       <= ROLE_WADDR;
            bit_cnt_reg    <= 4'd0;
            shifter_reg    <= 8'd0;
            bytes_left_reg <= 8'd0;
            ack_cnt_reg    <= 8'd0;
            index_reg      <= 8'd0;
            dir_reg        <= 1'b0;
            fail_reg       <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            role_reg       <= role_next;
            bit_cnt_reg    <= bit_cnt_next;
            shifter_reg    <= shifter_next;
            bytes_left_reg <= bytes_left_next;
            ack_cnt_reg    <= ack_cnt_next;
            index_reg      <= index_next;
            dir_reg        <= dir_next;
            fail_reg       <= fail_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_register_master_top.sv =====
// I2C register master: stream ports, configuration registers and pipeline registers.
//
// Every input item is one bus tick and yields exactly one output item carrying the
// SCL and SDA levels for that tick plus handshake and status flags. The block takes
// one tick per clock cycle: an item passes an input register, the sequencer computes
// its result in the same cycle as it updates the phase register, and the result sits
// in an output register, so throughput is one item per cycle while the output side
// keeps up. The sequencer phase register is the loop that sets this rate. Configuration
// writes take effect on the next tick and must be made while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_master_top
    import i2crm_pkg::*;
#(
    parameter int MAX_XFER = MAX_XFER_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // tdata from bit 0: start_request, read_not_write, reg_index[7:0],
    // xfer_length[7:0], write_byte[7:0], sda_in, five zero bits.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,
    // tdata from bit 0: scl_level, sda_release, busy_res, write_take,
    // read_data[7:0], read_valid, done_res, status[1:0].
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

    logic    in_valid_reg;
    tick_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_item_reg;
    cfg_t    cfg_reg;
    logic    advance;
    tick_t   in_item;
    result_t res;

    assign in_item.start_request  = s_tdata[0];
    assign in_item.read_not_write = s_tdata[1];
    assign in_item.reg_index      = s_tdata[9:2];
    assign in_item.xfer_length    = s_tdata[17:10];
    assign in_item.write_byte     = s_tdata[25:18];
    assign in_item.sda_in         = s_tdata[26];

    // A held item moves on when the output register is free or being emptied.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= DEV_ADDR_RST;
            cfg_reg.ack_wait_limit <= ACK_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DEV_ADDR:  cfg_reg.device_address <= cfg_data[6:0];
                CFG_ACK_LIMIT: cfg_reg.ack_wait_limit <= cfg_data;
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= in_item;
        end
    end

    i2crm_engine #(
        .MAX_XFER (MAX_XFER)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .tick    (in_item_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_item_reg.read_last;
    assign m_tdata  = {out_item_reg.status, out_item_reg.done_res, out_item_reg.read_valid,
                       out_item_reg.read_data, out_item_reg.write_take,
                       out_item_reg.busy_res, out_item_reg.sda_release,
                       out_item_reg.scl_level};

endmodule

`default_nettype wire

// ===== hw/rtl/i2crm_checker.sv =====
// Port-level checks for the I2C register master, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module i2crm_checker
    import i2crm_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast
);

    // A refused request finishes without ever going busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[13] && (m_tdata[15:14] == STATUS_TOO_BIG) |-> !m_tdata[2])
        else $error("length refusal reported while busy");

    // The last-byte mark comes only with a received byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[12])
        else $error("read_last without read_valid");

    // Status is reported only on the finishing item.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[13] |-> (m_tdata[15:14] == STATUS_SUCCESS))
        else $error("status outside done item");

    // Received data is zero unless a byte completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[12] |-> (m_tdata[11:4] == 8'd0))
        else $error("read_data nonzero without read_valid");

    // A stalled result item holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output item changed");

endmodule

bind i2c_register_master_top i2crm_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
